// ===== hdl/mesh_relay_route_and_dedup_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Mesh relay route and dedup unit: assertion macros
// Immediate-implication and next-cycle-implication property shorthands.
// ----------------------------------------------------------------------------
`ifndef MESH_RELAY_ROUTE_AND_DEDUP_UNIT_MACROS_SVH
`define MESH_RELAY_ROUTE_AND_DEDUP_UNIT_MACROS_SVH

// hold cons in the same cycle as ante
`define MRRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// hold cons in the cycle after ante
`define MRRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mrrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Mesh relay route and dedup package
// Constants, codes, the route memory request type and the relay mask function.
// ----------------------------------------------------------------------------
package mrrd_pkg;

  localparam int NumCh      = 6;
  localparam int MaxPayload = 32;
  localparam int DedupDepth = 8;
  localparam int DedupW     = $clog2(DedupDepth);
  localparam int RouteDepth = 256;

  localparam logic [7:0] AddrAll      = 8'hff;
  localparam logic [7:0] AddrNeighbor = 8'hfe;
  localparam logic [7:0] CmdAckReq    = 8'hf1;
  localparam logic [7:0] CmdOffline   = 8'hf2;
  localparam logic [7:0] OwnReset     = 8'h06;
  localparam logic [2:0] NoRoute      = 3'd7;

  localparam logic [1:0] StatusBad     = 2'd0;
  localparam logic [1:0] StatusDup     = 2'd1;
  localparam logic [1:0] StatusAccept  = 2'd2;
  localparam logic [1:0] StatusCleared = 2'd3;

  typedef struct packed {
    logic       re;
    logic [7:0] raddr;
    logic       we;
    logic [7:0] waddr;
    logic [2:0] wdata;
  } rt_req_t;

  // relay mask for route entry r; excl drops channel from when flooding
  function automatic logic [NumCh-1:0] route_mask(logic [2:0] r, logic [NumCh-1:0] act,
                                                  logic excl, logic [2:0] from);
    logic [NumCh-1:0] m;
    m = '0;
    if (r != 3'd0 && r < 3'(NumCh)) begin
      m[r] = act[r];
    end else begin
      for (int i = 0; i < NumCh; i++) begin
        if (act[i] && !(excl && from == 3'(i))) begin
          m[i] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

// ===== hdl/mesh_relay_route_and_dedup_unit.sv =====
// ----------------------------------------------------------------------------
// Mesh relay route and dedup unit
// Checks, deduplicates and routes one received packet header per word.
// ----------------------------------------------------------------------------
// Each input word is a packet header or a channel-silence notice (tuser) and
// yields exactly one result word. An accepted packet passes the evaluate and
// learn states before the unit is ready again: acceptance issues the route
// table read, the evaluate state uses the read data and may write a removed
// route, and the learn state writes the route learned for the source. Dropped
// packets and silence notices skip the learn state. The route table is a
// synchronous memory with one read and one write port, hence these separate
// steps; a full result register stalls evaluation until the result is taken.
// The route table is usable straight out of reset, with no clearing pass.
module mesh_relay_route_and_dedup_unit
  import mrrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,     // own_address
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // channel, src_addr, dst_addr, payload_length, serial, payload_sum,
  // check_byte, first_byte, second_byte
  input  logic [71:0] s_axis_tdata_i,
  input  logic        s_axis_tuser_i,  // action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // forward_mask, deliver_local, reply_valid, reply_mask, reply_serial,
  // reply_checksum
  output logic [31:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o   // status
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_LEARN = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [7:0]        own_q;
  logic [66:0]       item_q;
  logic              action_q;
  logic [31:0]       ring_q [DedupDepth];
  logic [DedupDepth-1:0] ring_vld_q;
  logic [DedupW-1:0] wptr_q;
  logic [NumCh-1:0]  active_q, active_d;
  logic [7:0]        serial_q;
  logic              out_valid_q;
  logic [31:0]       out_data_q;
  logic [1:0]        out_user_q;

  rt_req_t    rt_req;
  logic [2:0] rt_rdata;

  logic       in_acc, go;
  logic [7:0] in_dst;
  logic       in_local;

  logic [2:0] ch;
  logic [7:0] src, dst, len, ser, psum, chk, b0, b1, sum_w, arg;
  logic [31:0] hdr;
  logic       ch_ok, bad, dup, is_local, reply, offline, accept;
  logic [1:0] status;
  logic [NumCh-1:0] fwd, rmask;
  logic [7:0] rsum;

  mrrd_route_mem u_route_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rt_req),
    .rdata_o (rt_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_dst          = s_axis_tdata_i[18:11];
  assign in_local        = (in_dst == AddrAll) || (in_dst == AddrNeighbor) || (in_dst == own_q);

  assign ch   = item_q[2:0];
  assign src  = item_q[10:3];
  assign dst  = item_q[18:11];
  assign len  = item_q[26:19];
  assign ser  = item_q[34:27];
  assign psum = item_q[42:35];
  assign chk  = item_q[50:43];
  assign b0   = item_q[58:51];
  assign b1   = item_q[66:59];

  assign go = (state_q == S_EVAL) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    sum_w    = src + dst + len + ser + psum;
    ch_ok    = ch < 3'(NumCh);
    bad      = !ch_ok || (len > 8'(MaxPayload)) || (sum_w != chk);
    hdr      = {ser, len, dst, src};
    dup      = 1'b0;
    for (int i = 0; i < DedupDepth; i++) begin
      if (ring_vld_q[i] && ring_q[i] == hdr) begin
        dup = 1'b1;
      end
    end
    is_local = (dst == AddrAll) || (dst == AddrNeighbor) || (dst == own_q);
    accept   = !action_q && !bad && !dup;
    reply    = accept && is_local && (len != 8'd0) && (b0 == CmdAckReq);
    offline  = accept && is_local && (len != 8'd0) && (b0 == CmdOffline);
    arg      = (len == 8'd1) ? chk : b1;

    if (action_q) begin
      status = StatusCleared;
    end else if (bad) begin
      status = StatusBad;
    end else if (dup) begin
      status = StatusDup;
    end else begin
      status = StatusAccept;
    end

    fwd = '0;
    if (accept) begin
      if (dst == AddrAll) begin
        fwd = route_mask(3'd0, active_q, 1'b1, ch);
      end else if (!is_local) begin
        fwd = route_mask(rt_rdata, active_q, 1'b1, ch);
      end
    end
    rmask = reply ? route_mask(rt_rdata, active_q, 1'b0, ch) : '0;
    rsum  = reply ? (own_q + src + serial_q) : 8'd0;

    active_d = active_q;
    if (action_q) begin
      if (ch_ok) begin
        active_d[ch] = 1'b0;
      end
    end else if (accept) begin
      active_d[ch] = 1'b1;
    end
  end

  always_comb begin
    rt_req.re    = in_acc;
    rt_req.raddr = in_local ? s_axis_tdata_i[10:3] : in_dst;
    rt_req.we    = 1'b0;
    rt_req.waddr = src;
    rt_req.wdata = ch;
    if (state_q == S_EVAL) begin
      rt_req.we    = go && offline;
      rt_req.waddr = arg;
      rt_req.wdata = NoRoute;
    end else if (state_q == S_LEARN) begin
      rt_req.we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EVAL;
      S_EVAL:  if (go) state_d = accept ? S_LEARN : S_IDLE;
      S_LEARN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q   <= s_axis_tdata_i[66:0];
      action_q <= s_axis_tuser_i;
    end
    if (go && accept) begin
      ring_q[wptr_q] <= hdr;
    end
    if (go) begin
      out_user_q <= status;
      out_data_q <= {2'b00, rsum, (reply ? serial_q : 8'd0), rmask, reply,
                     accept && is_local, fwd};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      own_q       <= OwnReset;
      ring_vld_q  <= '0;
      wptr_q      <= '0;
      active_q    <= '0;
      serial_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        own_q <= cfg_wdata_i;
      end
      if (go) begin
        active_q <= active_d;
        if (accept) begin
          ring_vld_q[wptr_q] <= 1'b1;
          wptr_q <= (wptr_q == DedupW'(DedupDepth - 1)) ? '0 : wptr_q + 1'b1;
        end
        if (reply) begin
          serial_q <= serial_q + 8'd1;
        end
      end
      if (go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ===== hdl/mrrd_route_mem.sv =====
// ----------------------------------------------------------------------------
// Mesh relay route memory
// 256 x 3 route table, one write and one registered read port, per-entry
// valid bits so that an unwritten entry reads as no route.
// ----------------------------------------------------------------------------
module mrrd_route_mem
  import mrrd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  rt_req_t    req_i,
  output logic [2:0] rdata_o
);

  logic [2:0]            mem_q [RouteDepth];
  logic [RouteDepth-1:0] vld_q;
  logic [2:0]            rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem_q[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_vld_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : NoRoute;

endmodule

// ===== hdl/mrrd_checker.sv =====
// ----------------------------------------------------------------------------
// Mesh relay route and dedup checker
// Port-level assertions on result words and input flow, bound to the top level.
// ----------------------------------------------------------------------------
`include "mesh_relay_route_and_dedup_unit_macros.svh"

module mrrd_checker
  import mrrd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  `MRRD_ASSERT_NOW(a_drop_fields_zero,
                   m_axis_tvalid_o && m_axis_tuser_o != StatusAccept,
                   m_axis_tdata_o == 32'd0, "non-accepted word carries data")
  `MRRD_ASSERT_NOW(a_reply_fields_zero, m_axis_tvalid_o && !m_axis_tdata_o[7],
                   m_axis_tdata_o[31:8] == 24'd0, "reply fields set without reply")
  `MRRD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o,
                    !s_axis_tready_o, "word accepted while busy")
  `MRRD_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
                    "stalled result changed")

endmodule

bind mesh_relay_route_and_dedup_unit mrrd_checker u_mrrd_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Mesh relay route and dedup unit: testbench
// Drives packet headers and silence notices into the unit and compares every
// result word with a model of the relay, its route table and its dedup ring.
// ----------------------------------------------------------------------------
module tb_top;
  import mrrd_pkg::*;

  localparam logic ActPacket  = 1'b0;
  localparam logic ActSilence = 1'b1;
  localparam int   QuietLimit = 4000;
  localparam int   PhaseItems = 200;

  typedef struct packed {
    logic       action;
    logic [2:0] channel;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] len;
    logic [7:0] serial;
    logic [7:0] psum;
    logic [7:0] chk;
    logic [7:0] b0;
    logic [7:0] b1;
  } header_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [NumCh-1:0] fwd_mask;
    logic             deliver;
    logic             reply_on;
    logic [NumCh-1:0] reply_mask;
    logic [7:0]       reply_serial;
    logic [7:0]       reply_sum;
  } verdict_t;

  class relay_tracker;
    logic [2:0]       route_tab [RouteDepth];
    logic [31:0]      seen_hdr [DedupDepth];
    bit               seen_ok [DedupDepth];
    int unsigned      wr_slot;
    logic [NumCh-1:0] active;
    logic [7:0]       reply_ctr;
    logic [7:0]       own_addr;
    verdict_t         verdict_q [$];
    int unsigned      mismatches;

    function new();
      foreach (route_tab[i]) route_tab[i] = NoRoute;
      foreach (seen_hdr[i]) begin
        seen_hdr[i] = '0;
        seen_ok[i]  = 1'b0;
      end
      wr_slot    = 0;
      active     = '0;
      reply_ctr  = '0;
      own_addr   = OwnReset;
      mismatches = 0;
    endfunction

    function int pending();
      return verdict_q.size();
    endfunction

    function logic [NumCh-1:0] relay_mask(logic [2:0] r, int from);
      logic [NumCh-1:0] m;
      m = '0;
      if (r != 3'd0 && r < NumCh) begin
        m[r] = active[r];
      end else begin
        for (int i = 0; i < NumCh; i++) begin
          if (i != from && active[i]) m[i] = 1'b1;
        end
      end
      return m;
    endfunction

    function void note_header(header_t h);
      verdict_t    v;
      logic [31:0] key;
      bit          dup;
      logic [7:0]  arg;
      v = '0;
      if (h.action == ActSilence) begin
        if (h.channel < NumCh) active[h.channel] = 1'b0;
        v.status = StatusCleared;
      end else if (h.channel >= NumCh || h.len > MaxPayload ||
                   8'(h.src + h.dst + h.len + h.serial + h.psum) != h.chk) begin
        v.status = StatusBad;
      end else begin
        key = {h.serial, h.len, h.dst, h.src};
        dup = 1'b0;
        for (int i = 0; i < DedupDepth; i++) begin
          if (seen_ok[i] && seen_hdr[i] == key) dup = 1'b1;
        end
        if (dup) begin
          v.status = StatusDup;
        end else begin
          seen_hdr[wr_slot] = key;
          seen_ok[wr_slot]  = 1'b1;
          wr_slot           = (wr_slot + 1) % DedupDepth;
          v.status          = StatusAccept;
          if (h.dst == AddrAll) v.fwd_mask = relay_mask(3'd0, h.channel);
          if (h.dst == AddrAll || h.dst == AddrNeighbor || h.dst == own_addr) begin
            v.deliver = 1'b1;
            if (h.len != 8'd0) begin
              if (h.b0 == CmdAckReq) begin
                v.reply_on     = 1'b1;
                v.reply_serial = reply_ctr;
                reply_ctr      = reply_ctr + 8'd1;
                v.reply_sum    = 8'(own_addr + h.src + v.reply_serial);
                v.reply_mask   = relay_mask(route_tab[h.src], -1);
              end else if (h.b0 == CmdOffline) begin
                arg            = (h.len == 8'd1) ? h.chk : h.b1;
                route_tab[arg] = NoRoute;
              end
            end
          end else begin
            v.fwd_mask = relay_mask(route_tab[h.dst], h.channel);
          end
          route_tab[h.src]  = h.channel;
          active[h.channel] = 1'b1;
        end
      end
      verdict_q.push_back(v);
    endfunction

    function void check_word(logic [1:0] status, logic [31:0] data);
      verdict_t v;
      verdict_t got;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d data %h", status, data);
        return;
      end
      v = verdict_q.pop_front();
      got.status       = status;
      got.fwd_mask     = data[5:0];
      got.deliver      = data[6];
      got.reply_on     = data[7];
      got.reply_mask   = data[13:8];
      got.reply_serial = data[21:14];
      got.reply_sum    = data[29:22];
      if (got.status != v.status || got.fwd_mask != v.fwd_mask ||
          got.deliver != v.deliver || got.reply_on != v.reply_on ||
          got.reply_mask != v.reply_mask || got.reply_serial != v.reply_serial ||
          got.reply_sum != v.reply_sum) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: status %0d/%0d fwd %h/%h local %0d/%0d",
                   $realtime, got.status, v.status, got.fwd_mask, v.fwd_mask,
                   got.deliver, v.deliver);
          $display("  reply %0d/%0d mask %h/%h serial %h/%h sum %h/%h (got/exp)",
                   got.reply_on, v.reply_on, got.reply_mask, v.reply_mask,
                   got.reply_serial, v.reply_serial, got.reply_sum, v.reply_sum);
        end
      end
    endfunction
  endclass

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic [71:0] s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tready  = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  relay_tracker sb;
  header_t      recent_sent [$];
  int           idle_pct  = 0;
  int           stall_pct = 0;
  int           quiet     = 0;

  mesh_relay_route_and_dedup_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) sb.check_word(m_axis_tuser_o, m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  function automatic header_t pkt(logic [2:0] ch, logic [7:0] src, logic [7:0] dst,
                                  logic [7:0] len, logic [7:0] ser, logic [7:0] psum,
                                  logic [7:0] b0, logic [7:0] b1);
    header_t h;
    h = '{ActPacket, ch, src, dst, len, ser, psum, 8'(src + dst + len + ser + psum), b0, b1};
    return h;
  endfunction

  function automatic header_t silence(logic [2:0] ch);
    header_t h;
    h         = '0;
    h.action  = ActSilence;
    h.channel = ch;
    return h;
  endfunction

  function automatic logic [7:0] draw_addr();
    return ($urandom_range(99) < 80) ? 8'(8'h10 + $urandom_range(7)) : 8'($urandom_range(255));
  endfunction

  function automatic header_t draw_header();
    header_t h;
    int      roll;
    int      pick;
    roll = $urandom_range(99);
    if (roll < 8 && recent_sent.size() != 0) begin
      h         = recent_sent[$urandom_range(recent_sent.size() - 1)];
      h.channel = 3'($urandom_range(NumCh - 1));
      return h;
    end
    h.action  = ActPacket;
    h.channel = 3'($urandom_range(NumCh - 1));
    h.src     = draw_addr();
    pick      = $urandom_range(99);
    if (pick < 30)      h.dst = sb.own_addr;
    else if (pick < 48) h.dst = AddrAll;
    else if (pick < 60) h.dst = AddrNeighbor;
    else                h.dst = draw_addr();
    pick = $urandom_range(99);
    if (pick < 10)      h.len = 8'd0;
    else if (pick < 20) h.len = 8'd1;
    else if (pick < 25) h.len = 8'(MaxPayload);
    else                h.len = 8'($urandom_range(MaxPayload - 1, 2));
    h.serial = 8'($urandom_range(255));
    h.psum   = 8'($urandom_range(255));
    pick     = $urandom_range(99);
    if (pick < 65)      h.b0 = CmdAckReq;
    else if (pick < 80) h.b0 = CmdOffline;
    else                h.b0 = 8'($urandom_range(255));
    h.b1 = draw_addr();
    if (roll < 13) begin
      h.action  = ActSilence;
      h.channel = 3'($urandom_range(7));
    end else if (roll < 16) begin
      h.channel = 3'($urandom_range(7, NumCh));
    end else if (roll < 19) begin
      h.len = 8'($urandom_range(255, MaxPayload + 1));
    end
    h.chk = 8'(h.src + h.dst + h.len + h.serial + h.psum);
    if (roll >= 19 && roll < 23) begin
      h.chk = h.chk ^ 8'($urandom_range(255, 1));
    end else if (roll >= 23) begin
      recent_sent.push_back(h);
      if (recent_sent.size() > 12) void'(recent_sent.pop_front());
    end
    return h;
  endfunction

  task automatic send_word(header_t h);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, h.b1, h.b0, h.chk, h.psum, h.serial, h.len, h.dst, h.src, h.channel};
    s_tuser  <= h.action;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_header(h);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_own(logic [7:0] a);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= a;
    @(posedge clk_i);
    cfg_we      <= 1'b0;
    sb.own_addr = a;
  endtask

  initial begin
    int         idle_tab [4];
    int         stall_tab [4];
    logic [7:0] own_tab [4];
    header_t    h;
    idle_tab  = '{0, 77, 0, 38};
    stall_tab = '{0, 0, 77, 38};
    own_tab   = '{8'h00, 8'hff, 8'($urandom_range(253, 1)), AddrNeighbor};
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(pkt(3'd0, 8'h00, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
    send_word(pkt(3'd0, 8'h00, 8'h00, 8'd0, 8'd0, 8'h00, 8'h00, 8'h00));
    send_word(pkt(3'd1, 8'h10, AddrAll, 8'd2, 8'd1, 8'h33, 8'h00, 8'h00));
    send_word(pkt(3'd2, 8'h20, AddrNeighbor, 8'd1, 8'd2, 8'h44, 8'h00, 8'h00));
    send_word(pkt(3'd3, 8'h30, OwnReset, 8'd2, 8'd3, 8'h12, CmdAckReq, 8'h00));
    send_word(pkt(3'd4, 8'h40, 8'h10, 8'd4, 8'd4, 8'h21, 8'h00, 8'h00));
    send_word(silence(3'd1));
    send_word(pkt(3'd5, 8'h50, 8'h10, 8'd4, 8'd5, 8'h9c, 8'h00, 8'h00));
    send_word(pkt(3'd0, 8'h51, 8'h30, 8'd3, 8'd6, 8'h0f, 8'h00, 8'h00));
    // single payload byte: the offline argument is the check byte, aimed at 0x30
    send_word(pkt(3'd2, 8'h22, OwnReset, 8'd1, 8'd6,
                  8'h30 - 8'h22 - OwnReset - 8'd1 - 8'd6, CmdOffline, 8'h00));
    send_word(pkt(3'd0, 8'h01, 8'h30, 8'd3, 8'd7, 8'h05, 8'h00, 8'h00));
    send_word(pkt(3'd4, 8'h44, OwnReset, 8'd2, 8'd7, 8'h77, CmdOffline, 8'h44));
    send_word(pkt(3'd1, 8'h02, 8'h44, 8'd5, 8'd8, 8'h3c, 8'h00, 8'h00));
    send_word(pkt(3'd3, 8'h55, OwnReset, 8'd0, 8'd8, 8'h00, CmdAckReq, 8'h00));
    send_word(pkt(3'd5, 8'h66, 8'h99, 8'(MaxPayload), 8'd9, 8'hab, 8'h00, 8'h00));
    send_word(pkt(3'd5, 8'h67, 8'h99, 8'(MaxPayload + 1), 8'd9, 8'hab, 8'h00, 8'h00));
    send_word(pkt(3'd2, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    h     = pkt(3'd1, 8'h12, 8'h13, 8'd3, 8'd10, 8'h5a, 8'h00, 8'h00);
    h.chk = h.chk ^ 8'h01;
    send_word(h);
    send_word(pkt(3'd6, 8'h12, 8'h13, 8'd3, 8'd11, 8'h5a, 8'h00, 8'h00));
    send_word(pkt(3'd7, 8'h12, 8'h13, 8'd3, 8'd12, 8'h5a, 8'h00, 8'h00));
    send_word(silence(3'd7));
    send_word(silence(3'd6));
    send_word(pkt(3'd5, 8'hff, AddrNeighbor, 8'(MaxPayload), 8'hff, 8'hff, 8'hff, 8'hff));
    send_word(pkt(3'd2, 8'h44, OwnReset, 8'd3, 8'd13, 8'h81, CmdAckReq, 8'h00));
    send_word(pkt(3'd3, 8'h77, 8'h00, 8'd2, 8'd14, 8'h19, 8'h00, 8'h00));

    for (int p = 0; p < 4; p++) begin
      set_own(own_tab[p]);
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 0 && n == PhaseItems / 2) drain();
        send_word(draw_header());
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mrrd_pkg.sv
hdl/mrrd_route_mem.sv
hdl/mesh_relay_route_and_dedup_unit.sv
hdl/mrrd_checker.sv
verif/tb_top.sv
